@@ hdl/hamming_top_k_ranker_defines.svh @@
// Assertion macros shared by the ranker modules.
`ifndef HAMMING_TOP_K_RANKER_DEFINES_SVH
`define HAMMING_TOP_K_RANKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define HKR_ASSERT_NOW(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define HKR_ASSERT_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

@@ hdl/hkr_pkg.sv @@
// Shared types and constants of the Hamming top-K ranker.
package hkr_pkg;

	localparam int FP_W        = 64;
	localparam int DIST_W      = 7;
	localparam int ID_W        = 17;
	localparam int RANK_W      = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 64;

	localparam logic [DIST_W-1:0]      EMPTY_DIST     = 7'd127;
	localparam logic signed [ID_W-1:0] EMPTY_ID       = -17'sd1;
	localparam logic                   CFG_IDX_TARGET = 1'b0;

	typedef struct packed {
		logic                   last;
		logic [DIST_W-1:0]      distance;
		logic signed [ID_W-1:0] id;
	} item_t;

endpackage

@@ hdl/hkr_front.sv @@
// Front end: accepts fingerprints, computes distance and assigns ids.
module hkr_front #(
	parameter int MAX_ITEMS = 65536
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [hkr_pkg::FP_W-1:0]     fingerprint,
	input  logic                         last_item,
	input  logic [hkr_pkg::FP_W-1:0]     target,
	input  logic                         queue_full,
	output logic                         push,
	output hkr_pkg::item_t               push_item
);

	localparam int CNT_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS - 1);

	function automatic logic [hkr_pkg::DIST_W-1:0] popcount64(input logic [63:0] x);
		logic [3:0]                  byte_cnt [8];
		logic [hkr_pkg::DIST_W-1:0] sum;
		sum = '0;
		for (int b = 0; b < 8; b++) begin
			byte_cnt[b] = '0;
			for (int j = 0; j < 8; j++) begin
				byte_cnt[b] = byte_cnt[b] + 4'(x[8*b+j]);
			end
		end
		for (int b = 0; b < 8; b++) begin
			sum = sum + hkr_pkg::DIST_W'(byte_cnt[b]);
		end
		return sum;
	endfunction

	logic                 valid_s1;
	hkr_pkg::item_t       item_s1;
	logic [CNT_W-1:0]     cnt_q;
	logic                 accept;

	assign push      = valid_s1 && !queue_full;
	assign in_stall  = valid_s1 && queue_full;
	assign accept    = in_valid && !in_stall;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= '0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			if (last_item || cnt_q == CNT_MAX) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.last     <= last_item;
			item_s1.distance <= popcount64(fingerprint ^ target);
			item_s1.id       <= hkr_pkg::ID_W'(cnt_q);
		end
	end

endmodule

@@ hdl/hkr_queue.sv @@
// Short FIFO between the front end and the ranking back end.
`include "hamming_top_k_ranker_defines.svh"
module hkr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hkr_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           pop_valid,
	output hkr_pkg::item_t pop_item
);

	localparam int DEPTH = hkr_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	hkr_pkg::item_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = count_q == CNT_W'(DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	`HKR_ASSERT_NOW(a_no_overflow, push, !full, "push into full queue")
	`HKR_ASSERT_NOW(a_no_underflow, pop, pop_valid, "pop from empty queue")
	`HKR_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "queue count out of range")

endmodule

@@ hdl/hkr_back.sv @@
// Back end: sorted top-K list, insertion and drain of results.
`include "hamming_top_k_ranker_defines.svh"
module hkr_back #(
	parameter int LIST_SIZE = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	input  hkr_pkg::item_t                      item,
	output logic                                item_pop,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [hkr_pkg::RANK_W-1:0]          rank,
	output logic signed [hkr_pkg::ID_W-1:0]     entry_id,
	output logic [hkr_pkg::DIST_W-1:0]          entry_distance,
	output logic                                last_result
);

	localparam int IDX_W = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LIST_SIZE - 1);

	typedef enum logic [1:0] {
		ST_RUN   = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

	state_t                          state_q;
	logic [IDX_W-1:0]                drain_idx_q;
	logic [hkr_pkg::DIST_W-1:0]      sd_q  [LIST_SIZE];
	logic signed [hkr_pkg::ID_W-1:0] sid_q [LIST_SIZE];
	logic [hkr_pkg::DIST_W-1:0]      nd    [LIST_SIZE];
	logic signed [hkr_pkg::ID_W-1:0] nid   [LIST_SIZE];
	logic [LIST_SIZE-1:0]            better;
	logic                            load;
	logic                            drain_end;
	logic                            out_valid_q;
	logic [hkr_pkg::RANK_W-1:0]      rank_q;
	logic signed [hkr_pkg::ID_W-1:0] id_q;
	logic [hkr_pkg::DIST_W-1:0]      dist_q;
	logic                            last_q;

	assign item_pop  = item_valid && (state_q == ST_RUN);
	assign load      = (state_q == ST_DRAIN) && (!out_valid_q || !out_stall);
	assign drain_end = drain_idx_q == IDX_LAST;

	assign out_valid      = out_valid_q;
	assign rank           = rank_q;
	assign entry_id       = id_q;
	assign entry_distance = dist_q;
	assign last_result    = last_q;

	always_comb begin
		for (int i = 0; i < LIST_SIZE; i++) begin
			better[i] = (item.distance < sd_q[i]) ||
			            ((item.distance == sd_q[i]) && (item.id < sid_q[i]));
		end
		for (int i = 0; i < LIST_SIZE; i++) begin
			if (!better[i]) begin
				nd[i]  = sd_q[i];
				nid[i] = sid_q[i];
			end else if (i == 0) begin
				nd[i]  = item.distance;
				nid[i] = item.id;
			end else if (!better[i-1]) begin
				nd[i]  = item.distance;
				nid[i] = item.id;
			end else begin
				nd[i]  = sd_q[i-1];
				nid[i] = sid_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			drain_idx_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < LIST_SIZE; i++) begin
				sd_q[i]  <= hkr_pkg::EMPTY_DIST;
				sid_q[i] <= hkr_pkg::EMPTY_ID;
			end
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (item_pop) begin
				for (int i = 0; i < LIST_SIZE; i++) begin
					sd_q[i]  <= nd[i];
					sid_q[i] <= nid[i];
				end
			end else if (load) begin
				// shift up; empties fill in from the bottom, clearing the list
				for (int i = 0; i < LIST_SIZE - 1; i++) begin
					sd_q[i]  <= sd_q[i+1];
					sid_q[i] <= sid_q[i+1];
				end
				sd_q[LIST_SIZE-1]  <= hkr_pkg::EMPTY_DIST;
				sid_q[LIST_SIZE-1] <= hkr_pkg::EMPTY_ID;
			end

			unique case (state_q)
				ST_RUN: begin
					if (item_pop && item.last) begin
						state_q     <= ST_DRAIN;
						drain_idx_q <= '0;
					end
				end
				ST_DRAIN: begin
					if (load) begin
						if (drain_end) begin
							state_q <= ST_RUN;
						end else begin
							drain_idx_q <= drain_idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rank_q <= hkr_pkg::RANK_W'(drain_idx_q);
			id_q   <= sid_q[0];
			dist_q <= sd_q[0];
			last_q <= drain_end;
		end
	end

	`HKR_ASSERT_NOW(a_no_pop_in_drain, state_q == ST_DRAIN, !item_pop, "pop during drain")
	`HKR_ASSERT_NEXT(a_cleared_after_drain, load && drain_end,
		sd_q[0] == hkr_pkg::EMPTY_DIST && sid_q[0] == hkr_pkg::EMPTY_ID, "list not cleared")
	`HKR_ASSERT_NEXT(a_drain_starts_at_head, item_pop && item.last,
		drain_idx_q == '0 && state_q == ST_DRAIN, "drain did not start")

endmodule

@@ hdl/hamming_top_k_ranker.sv @@
// Top level of the Hamming-distance top-K ranker.
//
// Input channel (in_valid/in_stall): one 64-bit fingerprint per beat, with
// last_item marking the end of a search. Each beat gets the next id from an
// internal counter (modulo MAX_ITEMS) and its distance is the popcount of
// fingerprint XOR target. Ordinary items are taken one per cycle while the
// queue is not full; they pass a register stage and a 4-entry queue and are
// ranked one per cycle outside a drain. After the last item is ranked, the
// back end drains LIST_SIZE result beats (rank, entry_id, entry_distance,
// last_result on the final one), one per cycle while out_stall is low, and
// clears the list; the id counter restarts once the last item is taken.
// During the drain the queue still fills, so input stalls only once it is
// full. A last item passes the front register stage, the queue and the list
// before its first result beat reaches the result register.
// out_stall holds the result register; input backs up through the queue.
// Reset clears the list to empty slots (id -1, distance 127), the counter,
// the target register and both channels. The target is written over the
// APB port at addresses 0 to 7 (64-bit data).
module hamming_top_k_ranker #(
	parameter int LIST_SIZE = 8,
	parameter int MAX_ITEMS = 65536
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [hkr_pkg::ADDR_W-1:0]          paddr,
	input  logic [hkr_pkg::DATA_W-1:0]          pwdata,
	output logic [hkr_pkg::DATA_W-1:0]          prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [hkr_pkg::FP_W-1:0]            fingerprint,
	input  logic                                last_item,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [hkr_pkg::RANK_W-1:0]          rank,
	output logic signed [hkr_pkg::ID_W-1:0]     entry_id,
	output logic [hkr_pkg::DIST_W-1:0]          entry_distance,
	output logic                                last_result
);

	logic [hkr_pkg::FP_W-1:0] target_q;
	logic                     sel_target;
	logic                     push;
	logic                     full;
	logic                     pop;
	logic                     pop_valid;
	hkr_pkg::item_t           push_item;
	hkr_pkg::item_t           pop_item;

	assign pready     = 1'b1;
	assign sel_target = paddr[3] == hkr_pkg::CFG_IDX_TARGET;
	assign prdata     = sel_target ? target_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (psel && penable && pwrite && pready && sel_target) begin
			target_q <= pwdata;
		end
	end

	hkr_front #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.fingerprint(fingerprint),
		.last_item  (last_item),
		.target     (target_q),
		.queue_full (full),
		.push       (push),
		.push_item  (push_item)
	);

	hkr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.full     (full),
		.pop      (pop),
		.pop_valid(pop_valid),
		.pop_item (pop_item)
	);

	hkr_back #(
		.LIST_SIZE(LIST_SIZE)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (pop_valid),
		.item          (pop_item),
		.item_pop      (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.rank          (rank),
		.entry_id      (entry_id),
		.entry_distance(entry_distance),
		.last_result   (last_result)
	);

endmodule
